@@ hw/rtl/rational_arithmetic_unit_defines.svh @@
// ----------------------------------------------------------------------------
// Rational arithmetic unit: assertion macros
// Shared same-cycle and next-cycle implication checks on the unit clock.
// ----------------------------------------------------------------------------
`ifndef RATIONAL_ARITHMETIC_UNIT_DEFINES_SVH
`define RATIONAL_ARITHMETIC_UNIT_DEFINES_SVH

// same-cycle implication
`define RAU_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("rational_arithmetic_unit: implication check failed");

// next-cycle implication
`define RAU_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("rational_arithmetic_unit: next-cycle check failed");

`endif

@@ hw/rtl/rau_pkg.sv @@
// ----------------------------------------------------------------------------
// rau_pkg
// Constants, operation codes, status codes and sequencer states.
// ----------------------------------------------------------------------------
package rau_pkg;

   localparam int WIDTH  = 32;
   localparam int PROD_W = 2 * WIDTH;
   localparam int CNT_W  = $clog2(PROD_W);

   localparam logic [2:0] KIND_ADD  = 3'd0;
   localparam logic [2:0] KIND_SUB  = 3'd1;
   localparam logic [2:0] KIND_MUL  = 3'd2;
   localparam logic [2:0] KIND_DIV  = 3'd3;
   localparam logic [2:0] KIND_CMP  = 3'd4;
   localparam logic [2:0] KIND_NORM = 3'd5;

   localparam logic [PROD_W-1:0] MAG_TOP = PROD_W'(1) << (WIDTH - 1);

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_ERROR    = 2'd1,
      STATUS_OVERFLOW = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL,
      ST_SUM,
      ST_GCD_K,
      ST_GCD_X,
      ST_GCD_Y,
      ST_DIV_N,
      ST_DIV_D,
      ST_DONE
   } state_type;

endpackage

@@ hw/rtl/rational_arithmetic_unit.sv @@
// Sequence: errors go straight to the result; other requests take 3 multiplies
// and a sum, where compare and zero results end, else a binary GCD of one step
// per cycle, then two restoring divisions by the GCD.
// One request at a time: req_tready is high only in the idle state. Synchronous
// active-high reset clears the sequencer and the output valid; payload
// registers are not reset.
// ----------------------------------------------------------------------------
// rational_arithmetic_unit
// Exact fraction add, subtract, multiply, divide, compare and normalize,
// reduced by the GCD, with zero-denominator and overflow status.
// ----------------------------------------------------------------------------
`include "rational_arithmetic_unit_defines.svh"

module rational_arithmetic_unit (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [127:0] req_tdata,  // a_num, a_den, b_num, b_den
   input  logic [2:0]   req_tuser,  // kind
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [63:0]  rsp_tdata,  // res_num, res_den, zero pad
   output logic [4:0]   rsp_tuser   // less, equal, greater, status
);

   localparam int W  = rau_pkg::WIDTH;
   localparam int PW = rau_pkg::PROD_W;
   localparam int CW = rau_pkg::CNT_W;

   rau_pkg::state_type state_ff, state_in;

   logic [2:0]    kind_ff, kind_in;
   logic [W-1:0]  an_ff, an_in, ad_ff, ad_in, bn_ff, bn_in, bd_ff, bd_in;
   logic          an_neg_ff, an_neg_in, bn_neg_ff, bn_neg_in;
   logic [PW-1:0] p_ff [3];
   logic [PW-1:0] p_in [3];
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [PW-1:0] num_ff, num_in, den_ff, den_in;
   logic          neg_ff, neg_in;
   logic [PW-1:0] gx_ff, gx_in, gy_ff, gy_in, g_ff, g_in;
   logic [CW-1:0] k_ff, k_in;
   logic [PW-1:0] rem_ff, rem_in, dq_ff, dq_in, nm_ff, nm_in;

   // pending result
   logic [W-1:0]   pnum_ff, pnum_in;
   logic [W-2:0]   pden_ff, pden_in;
   logic [2:0]     pflag_ff, pflag_in;
   rau_pkg::status_type pstat_ff, pstat_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [63:0]   rsp_data_ff, rsp_data_in;
   logic [4:0]    rsp_user_ff, rsp_user_in;

   // input decode
   logic [W-1:0] f_an, f_ad, f_bn, f_bd, m_an, m_ad, m_bn, m_bd;
   logic         in_err;

   // shared units
   logic [W-1:0]  mx, my;
   logic [PW-1:0] prod;
   logic          s0, s1, sum_neg;
   logic [PW-1:0] sum_mag;
   logic [PW:0]   r2;
   logic          ge;
   logic [PW-1:0] rem_step, dq_step;
   logic          out_free, ovf;

   assign f_an = req_tdata[31:0];
   assign f_ad = req_tdata[63:32];
   assign f_bn = req_tdata[95:64];
   assign f_bd = req_tdata[127:96];
   assign m_an = f_an[W-1] ? (~f_an + W'(1)) : f_an;
   assign m_ad = f_ad[W-1] ? (~f_ad + W'(1)) : f_ad;
   assign m_bn = f_bn[W-1] ? (~f_bn + W'(1)) : f_bn;
   assign m_bd = f_bd[W-1] ? (~f_bd + W'(1)) : f_bd;

   always_comb begin
      in_err = 1'b0;
      if (req_tuser > rau_pkg::KIND_NORM) in_err = 1'b1;
      if (m_ad == '0) in_err = 1'b1;
      if (req_tuser != rau_pkg::KIND_NORM && m_bd == '0) in_err = 1'b1;
      if (req_tuser == rau_pkg::KIND_DIV && m_bn == '0) in_err = 1'b1;
   end

   // operand pairs for the shared multiplier, one per cycle
   always_comb begin
      mx = '0;
      my = '0;
      case (cnt_ff[1:0])
         2'd0: begin
            mx = an_ff;
            case (kind_ff)
               rau_pkg::KIND_MUL:  my = bn_ff;
               rau_pkg::KIND_NORM: my = W'(1);
               default:            my = bd_ff;
            endcase
         end
         2'd1: begin
            if (kind_ff inside {rau_pkg::KIND_ADD, rau_pkg::KIND_SUB, rau_pkg::KIND_CMP}) begin
               mx = bn_ff;
               my = ad_ff;
            end
         end
         2'd2: begin
            mx = ad_ff;
            case (kind_ff)
               rau_pkg::KIND_DIV:  my = bn_ff;
               rau_pkg::KIND_NORM: my = W'(1);
               default:            my = bd_ff;
            endcase
         end
         default: ;
      endcase
   end

   assign prod = PW'(mx) * PW'(my);

   // signed-magnitude sum of the two numerator products; compare uses a - b
   always_comb begin
      s0 = (kind_ff inside {rau_pkg::KIND_MUL, rau_pkg::KIND_DIV}) ? (an_neg_ff ^ bn_neg_ff)
                                                                  : an_neg_ff;
      s1 = bn_neg_ff ^ (kind_ff inside {rau_pkg::KIND_SUB, rau_pkg::KIND_CMP});
      if (s0 == s1) begin
         sum_mag = p_ff[0] + p_ff[1];
         sum_neg = s0;
      end else if (p_ff[0] >= p_ff[1]) begin
         sum_mag = p_ff[0] - p_ff[1];
         sum_neg = s0;
      end else begin
         sum_mag = p_ff[1] - p_ff[0];
         sum_neg = s1;
      end
      if (sum_mag == '0) sum_neg = 1'b0;
   end

   // one restoring division step
   assign r2       = {rem_ff, dq_ff[PW-1]};
   assign ge       = r2 >= {1'b0, g_ff};
   assign rem_step = ge ? PW'(r2 - {1'b0, g_ff}) : r2[PW-1:0];
   assign dq_step  = {dq_ff[PW-2:0], ge};

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign ovf = (neg_ff ? (nm_ff > rau_pkg::MAG_TOP) : (nm_ff > rau_pkg::MAG_TOP - PW'(1)))
                || (dq_step > rau_pkg::MAG_TOP - PW'(1));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rau_pkg::ST_IDLE:
            if (req_tvalid) state_in = in_err ? rau_pkg::ST_DONE : rau_pkg::ST_MUL;
         rau_pkg::ST_MUL:
            if (cnt_ff[1:0] == 2'd2) state_in = rau_pkg::ST_SUM;
         rau_pkg::ST_SUM:
            if (kind_ff == rau_pkg::KIND_CMP || sum_mag == '0) state_in = rau_pkg::ST_DONE;
            else state_in = rau_pkg::ST_GCD_K;
         rau_pkg::ST_GCD_K:
            if (gx_ff[0] | gy_ff[0]) state_in = rau_pkg::ST_GCD_X;
         rau_pkg::ST_GCD_X:
            if (gx_ff[0]) state_in = rau_pkg::ST_GCD_Y;
         rau_pkg::ST_GCD_Y:
            if (gy_ff == '0) state_in = rau_pkg::ST_DIV_N;
         rau_pkg::ST_DIV_N:
            if (cnt_ff == CW'(PW - 1)) state_in = rau_pkg::ST_DIV_D;
         rau_pkg::ST_DIV_D:
            if (cnt_ff == CW'(PW - 1)) state_in = rau_pkg::ST_DONE;
         rau_pkg::ST_DONE:
            if (out_free) state_in = rau_pkg::ST_IDLE;
         default: state_in = rau_pkg::ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      kind_in   = kind_ff;
      an_in     = an_ff;
      ad_in     = ad_ff;
      bn_in     = bn_ff;
      bd_in     = bd_ff;
      an_neg_in = an_neg_ff;
      bn_neg_in = bn_neg_ff;
      p_in      = p_ff;
      cnt_in    = cnt_ff;
      num_in    = num_ff;
      den_in    = den_ff;
      neg_in    = neg_ff;
      gx_in     = gx_ff;
      gy_in     = gy_ff;
      g_in      = g_ff;
      k_in      = k_ff;
      rem_in    = rem_ff;
      dq_in     = dq_ff;
      nm_in     = nm_ff;
      pnum_in   = pnum_ff;
      pden_in   = pden_ff;
      pflag_in  = pflag_ff;
      pstat_in  = pstat_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      req_tready   = (state_ff == rau_pkg::ST_IDLE);

      case (state_ff)
         rau_pkg::ST_IDLE: begin
            kind_in   = req_tuser;
            an_in     = m_an;
            ad_in     = m_ad;
            bn_in     = m_bn;
            bd_in     = m_bd;
            an_neg_in = (f_an[W-1] ^ f_ad[W-1]) && (m_an != '0);
            bn_neg_in = (f_bn[W-1] ^ f_bd[W-1]) && (m_bn != '0);
            cnt_in    = '0;
            pnum_in   = '0;
            pden_in   = '0;
            pflag_in  = '0;
            pstat_in  = rau_pkg::STATUS_ERROR;
         end
         rau_pkg::ST_MUL: begin
            p_in[cnt_ff[1:0]] = prod;
            cnt_in = cnt_ff + CW'(1);
         end
         rau_pkg::ST_SUM: begin
            pstat_in = rau_pkg::STATUS_OK;
            pnum_in  = '0;
            pden_in  = '0;
            pflag_in = '0;
            if (kind_ff == rau_pkg::KIND_CMP) begin
               pflag_in = {!sum_neg && sum_mag != '0, sum_mag == '0, sum_neg};
            end else if (sum_mag == '0) begin
               pden_in = (W-1)'(1);
            end
            num_in = sum_mag;
            neg_in = sum_neg;
            den_in = p_ff[2];
            gx_in  = sum_mag;
            gy_in  = p_ff[2];
            k_in   = '0;
         end
         rau_pkg::ST_GCD_K: begin
            if (!(gx_ff[0] | gy_ff[0])) begin
               gx_in = gx_ff >> 1;
               gy_in = gy_ff >> 1;
               k_in  = k_ff + CW'(1);
            end
         end
         rau_pkg::ST_GCD_X: begin
            if (!gx_ff[0]) gx_in = gx_ff >> 1;
         end
         rau_pkg::ST_GCD_Y: begin
            if (gy_ff == '0) begin
               g_in   = gx_ff << k_ff;
               rem_in = '0;
               dq_in  = num_ff;
               cnt_in = '0;
            end else if (!gy_ff[0]) begin
               gy_in = gy_ff >> 1;
            end else if (gx_ff > gy_ff) begin
               gx_in = gy_ff;
               gy_in = gx_ff - gy_ff;
            end else begin
               gy_in = gy_ff - gx_ff;
            end
         end
         rau_pkg::ST_DIV_N: begin
            rem_in = rem_step;
            dq_in  = dq_step;
            cnt_in = cnt_ff + CW'(1);
            if (cnt_ff == CW'(PW - 1)) begin
               nm_in  = dq_step;
               rem_in = '0;
               dq_in  = den_ff;
               cnt_in = '0;
            end
         end
         rau_pkg::ST_DIV_D: begin
            rem_in = rem_step;
            dq_in  = dq_step;
            cnt_in = cnt_ff + CW'(1);
            if (cnt_ff == CW'(PW - 1)) begin
               if (ovf) begin
                  pstat_in = rau_pkg::STATUS_OVERFLOW;
                  pnum_in  = '0;
                  pden_in  = '0;
               end else begin
                  pstat_in = rau_pkg::STATUS_OK;
                  pnum_in  = neg_ff ? (W'(0) - nm_ff[W-1:0]) : nm_ff[W-1:0];
                  pden_in  = dq_step[W-2:0];
               end
            end
         end
         rau_pkg::ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {1'b0, pden_ff, pnum_ff};
               rsp_user_in  = {pstat_ff, pflag_ff};
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rau_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      an_ff       <= an_in;
      ad_ff       <= ad_in;
      bn_ff       <= bn_in;
      bd_ff       <= bd_in;
      an_neg_ff   <= an_neg_in;
      bn_neg_ff   <= bn_neg_in;
      p_ff        <= p_in;
      cnt_ff      <= cnt_in;
      num_ff      <= num_in;
      den_ff      <= den_in;
      neg_ff      <= neg_in;
      gx_ff       <= gx_in;
      gy_ff       <= gy_in;
      g_ff        <= g_in;
      k_ff        <= k_in;
      rem_ff      <= rem_in;
      dq_ff       <= dq_in;
      nm_ff       <= nm_in;
      pnum_ff     <= pnum_in;
      pden_ff     <= pden_in;
      pflag_ff    <= pflag_in;
      pstat_ff    <= pstat_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   `RAU_ASSERT_NXT(a_busy_after_accept, req_tvalid && req_tready, !req_tready)
   `RAU_ASSERT_IMP(a_flags_onehot0, rsp_tvalid, $onehot0(rsp_tuser[2:0]))
   `RAU_ASSERT_IMP(a_compare_no_data, rsp_tvalid && (rsp_tuser[2:0] != 3'd0), rsp_tdata == 64'd0)
   `RAU_ASSERT_IMP(a_ok_den_nonzero,
                   rsp_tvalid && (rsp_tuser[4:3] == 2'd0) && (rsp_tuser[2:0] == 3'd0),
                   rsp_tdata[62:32] != 31'd0)

endmodule
